// File: sv/tpps_pkg.sv
// Shared constants, types and the arctangent table of the track path point sampler.
package tpps_pkg;

	localparam int CORDIC_STAGES = 24;
	localparam int DIV_STEPS = 32;

	localparam int LW = 37;  // lap position and boundary width, Q21.16
	localparam int DW = 35;  // single segment length width
	localparam int CW = 34;  // CORDIC datapath width
	localparam int XW = 40;  // coordinate width before saturation

	localparam logic [29:0] PI_Q28      = 30'd843314857;
	localparam logic [30:0] TWO_PI_Q28  = 31'd1686629713;
	localparam logic [29:0] HALF_PI_Q28 = 30'd421657428;
	localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

	localparam logic [2:0] REG_RADIUS_BIG      = 3'd0;
	localparam logic [2:0] REG_RADIUS_SMALL    = 3'd1;
	localparam logic [2:0] REG_CENTER_DISTANCE = 3'd2;
	localparam logic [2:0] REG_TANGENT_LENGTH  = 3'd3;
	localparam logic [2:0] REG_TANGENT_ANGLE   = 3'd4;
	localparam logic [2:0] REG_COS_TANGENT     = 3'd5;
	localparam logic [2:0] REG_SIN_TANGENT     = 3'd6;

	typedef enum logic [1:0] {
		SEG_BIG_ARC   = 2'd0,
		SEG_UPPER     = 2'd1,
		SEG_SMALL_ARC = 2'd2,
		SEG_LOWER     = 2'd3
	} seg_t;

	// geometry derived from the registers
	typedef struct packed {
		logic [29:0]            t;
		logic [30:0]            two_t;
		logic [30:0]            span;
		logic [31:0]            rb;
		logic [31:0]            rs;
		logic [31:0]            cd;
		logic [31:0]            tl;
		logic [DW-1:0]          lim0;
		logic [DW-1:0]          lim2;
		logic [LW-1:0]          c1;
		logic [LW-1:0]          c2;
		logic [LW-1:0]          c3;
		logic [LW-1:0]          total;
		logic signed [35:0]     p1x;
		logic signed [35:0]     p2x;
		logic [32:0]            p1y;
		logic [32:0]            p2y;
		logic [35:0]            dx_mag;
		logic                   dx_neg;
		logic [33:0]            dz_mag;
		logic                   dz_neg;
	} geom_t;

	typedef struct packed {
		seg_t seg;
		logic none;
	} div_tag_t;

	typedef struct packed {
		seg_t                 seg;
		logic                 flip;
		logic signed [31:0]   h;
		logic signed [XW-1:0] linx;
		logic signed [XW-1:0] linz;
	} cor_tag_t;

	function automatic logic [29:0] atan_q30(input int i);
		logic [29:0] a;
		case (i)
			0: a = 30'd843314856;
			1: a = 30'd497837829;
			2: a = 30'd263043836;
			3: a = 30'd133525158;
			4: a = 30'd67021686;
			5: a = 30'd33543515;
			6: a = 30'd16775850;
			7: a = 30'd8388437;
			8: a = 30'd4194282;
			9: a = 30'd2097149;
			10: a = 30'd1048575;
			11: a = 30'd524287;
			12: a = 30'd262143;
			13: a = 30'd131071;
			14: a = 30'd65535;
			15: a = 30'd32767;
			16: a = 30'd16383;
			17: a = 30'd8191;
			18: a = 30'd4095;
			19: a = 30'd2047;
			20: a = 30'd1023;
			21: a = 30'd511;
			22: a = 30'd255;
			23: a = 30'd127;
			24: a = 30'd63;
			25: a = 30'd31;
			26: a = 30'd15;
			27: a = 30'd8;
			28: a = 30'd4;
			29: a = 30'd2;
			30: a = 30'd1;
			default: a = 30'd0;
		endcase
		return a;
	endfunction

endpackage

// File: sv/tpps_cfg.sv
// Geometry registers and the short pipeline that derives lengths and tangent end points.
module tpps_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output logic                busy,
	output tpps_pkg::geom_t     geom
);
	import tpps_pkg::*;

	logic [31:0]        rb_q, rs_q, cd_q, tl_q;
	logic [29:0]        ta_q;
	logic signed [31:0] cos_q;
	logic [30:0]        sin_q;
	logic [2:0]         busy_q;

	logic [29:0]        t_q;
	logic [DW-1:0]      lim0_q, lim2_q;
	logic [63:0]        cosrb_q, cosrs_q;
	logic [62:0]        sinrb_q, sinrs_q;
	logic               cos_neg_q;
	logic signed [35:0] p1x_q, p2x_q;
	logic [32:0]        p1y_q, p2y_q;
	logic [LW-1:0]      c1_q, c2_q, c3_q, total_q;
	logic [35:0]        dx_mag_q;
	logic               dx_neg_q;
	logic [33:0]        dz_mag_q;
	logic               dz_neg_q;

	logic [31:0]        cos_mag;
	logic signed [36:0] dx;
	logic signed [33:0] dz;

	assign cfg_ready = 1'b1;
	assign busy      = (busy_q != 3'd0);

	// hold busy out of reset until the derived geometry has settled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rb_q   <= 32'd65536;
			rs_q   <= 32'd65536;
			cd_q   <= 32'd262144;
			tl_q   <= 32'd262144;
			ta_q   <= 30'd421657428;
			cos_q  <= 32'sd0;
			sin_q  <= 31'd1073741824;
			busy_q <= 3'd4;
		end else if (cfg_valid) begin
			busy_q <= 3'd4;
			case (cfg_index)
				REG_RADIUS_BIG:      rb_q  <= cfg_data;
				REG_RADIUS_SMALL:    rs_q  <= cfg_data;
				REG_CENTER_DISTANCE: cd_q  <= cfg_data;
				REG_TANGENT_LENGTH:  tl_q  <= cfg_data;
				REG_TANGENT_ANGLE:   ta_q  <= cfg_data[29:0];
				REG_COS_TANGENT:     cos_q <= signed'(cfg_data);
				REG_SIN_TANGENT:     sin_q <= cfg_data[30:0];
				default: ;
			endcase
		end else if (busy_q != 3'd0) begin
			busy_q <= busy_q - 3'd1;
		end
	end

	assign cos_mag = cos_q[31] ? 32'(-cos_q) : 32'(cos_q);
	assign dx      = 37'(p2x_q) - 37'(p1x_q);
	assign dz      = signed'({1'b0, p2y_q}) - signed'({1'b0, p1y_q});

	// saturate angle, then products, then sums, then differences
	always_ff @(posedge clk) begin
		t_q       <= (ta_q > PI_Q28) ? PI_Q28 : ta_q;
		lim0_q    <= DW'((64'(rb_q) * 64'({PI_Q28 - t_q, 1'b0})) >> 28);
		lim2_q    <= DW'((64'(rs_q) * 64'({t_q, 1'b0})) >> 28);
		cosrb_q   <= 64'(cos_mag) * 64'(rb_q);
		cosrs_q   <= 64'(cos_mag) * 64'(rs_q);
		sinrb_q   <= 63'(64'(sin_q) * 64'(rb_q));
		sinrs_q   <= 63'(64'(sin_q) * 64'(rs_q));
		cos_neg_q <= cos_q[31];

		c1_q      <= LW'(lim0_q);
		c2_q      <= LW'(lim0_q) + LW'(tl_q);
		c3_q      <= LW'(lim0_q) + LW'(tl_q) + LW'(lim2_q);
		total_q   <= LW'(lim0_q) + LW'(tl_q) + LW'(lim2_q) + LW'(tl_q);
		p1x_q     <= cos_neg_q ? -signed'(36'(cosrb_q >> 30)) : signed'(36'(cosrb_q >> 30));
		p2x_q     <= signed'(36'(cd_q)) +
			(cos_neg_q ? -signed'(36'(cosrs_q >> 30)) : signed'(36'(cosrs_q >> 30)));
		p1y_q     <= 33'(sinrb_q >> 30);
		p2y_q     <= 33'(sinrs_q >> 30);

		dx_neg_q  <= dx[36];
		dx_mag_q  <= dx[36] ? 36'(-dx) : 36'(dx);
		dz_neg_q  <= dz[33];
		dz_mag_q  <= dz[33] ? 34'(-dz) : 34'(dz);
	end

	always_comb begin
		geom.t      = t_q;
		geom.two_t  = {t_q, 1'b0};
		geom.span   = TWO_PI_Q28 - {t_q, 1'b0};
		geom.rb     = rb_q;
		geom.rs     = rs_q;
		geom.cd     = cd_q;
		geom.tl     = tl_q;
		geom.lim0   = lim0_q;
		geom.lim2   = lim2_q;
		geom.c1     = c1_q;
		geom.c2     = c2_q;
		geom.c3     = c3_q;
		geom.total  = total_q;
		geom.p1x    = p1x_q;
		geom.p2x    = p2x_q;
		geom.p1y    = p1y_q;
		geom.p2y    = p2y_q;
		geom.dx_mag = dx_mag_q;
		geom.dx_neg = dx_neg_q;
		geom.dz_mag = dz_mag_q;
		geom.dz_neg = dz_neg_q;
	end

endmodule

// File: sv/tpps_div.sv
// Pipelined restoring divider giving the Q0.32 fraction num/den, one quotient bit per stage.
module tpps_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [tpps_pkg::DW-1:0] in_num,
	input  logic [tpps_pkg::DW-1:0] in_den,
	input  tpps_pkg::div_tag_t     in_tag,
	output logic                   out_valid,
	output logic [31:0]            out_q,
	output tpps_pkg::div_tag_t     out_tag
);
	import tpps_pkg::*;

	logic          vld_s [DIV_STEPS+1];
	logic [DW-1:0] rem_s [DIV_STEPS+1];
	logic [DW-1:0] den_s [DIV_STEPS+1];
	logic [31:0]   q_s   [DIV_STEPS+1];
	div_tag_t      tag_s [DIV_STEPS+1];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = in_num;
	assign den_s[0] = in_den;
	assign q_s[0]   = 32'd0;
	assign tag_s[0] = in_tag;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [DW:0] r2;
		logic        ge;
		assign r2 = {rem_s[k], 1'b0};
		assign ge = (r2 >= {1'b0, den_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? DW'(r2 - {1'b0, den_s[k]}) : DW'(r2);
				den_s[k+1] <= den_s[k];
				q_s[k+1]   <= {q_s[k][30:0], ge};
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_valid = vld_s[DIV_STEPS];
	assign out_q     = q_s[DIV_STEPS];
	assign out_tag   = tag_s[DIV_STEPS];

endmodule

// File: sv/tpps_cordic.sv
// Pipelined rotation-mode CORDIC, one micro-rotation per stage.
module tpps_cordic (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic signed [tpps_pkg::CW-1:0] in_z,
	input  tpps_pkg::cor_tag_t            in_tag,
	output logic                          out_valid,
	output logic signed [tpps_pkg::CW-1:0] out_x,
	output logic signed [tpps_pkg::CW-1:0] out_y,
	output tpps_pkg::cor_tag_t            out_tag
);
	import tpps_pkg::*;

	logic              vld_s [CORDIC_STAGES+1];
	logic signed [CW-1:0] x_s [CORDIC_STAGES+1];
	logic signed [CW-1:0] y_s [CORDIC_STAGES+1];
	logic signed [CW-1:0] z_s [CORDIC_STAGES+1];
	cor_tag_t          tag_s [CORDIC_STAGES+1];

	assign vld_s[0] = in_valid;
	assign x_s[0]   = GAIN_Q30;
	assign y_s[0]   = '0;
	assign z_s[0]   = in_z;
	assign tag_s[0] = in_tag;

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
		logic signed [CW-1:0] xs, ys, at;
		logic                 pos;
		assign xs  = x_s[k] >>> k;
		assign ys  = y_s[k] >>> k;
		assign at  = signed'(CW'(atan_q30(k)));
		assign pos = !z_s[k][CW-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1]   <= pos ? x_s[k] - ys : x_s[k] + ys;
				y_s[k+1]   <= pos ? y_s[k] + xs : y_s[k] - xs;
				z_s[k+1]   <= pos ? z_s[k] - at : z_s[k] + at;
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_valid = vld_s[CORDIC_STAGES];
	assign out_x     = x_s[CORDIC_STAGES];
	assign out_y     = y_s[CORDIC_STAGES];
	assign out_tag   = tag_s[CORDIC_STAGES];

endmodule

// File: sv/track_path_point_sampler.sv
// Top level of the track path point sampler: lap position, segment search and point output.
//
//   channel | direction | handshake         | payload
//   s_      | in        | s_tvalid/s_tready | s_tdata: phase
//   m_      | out       | m_tvalid/m_tready | m_tdata: pos_x, pos_z, heading, segment
//   cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One beat per cycle while the pipeline is not held (see below); the path runs through
// the 32-stage divider and the CORDIC pipeline.
// arst_n clears all valid bits and loads the register reset values.
// When m_tready is low with a result waiting, the whole pipeline holds.
// After a register write, and after reset, s_tready stays low while the geometry settles.
module track_path_point_sampler (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // [31:0] phase
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // [31:0] pos_x, [63:32] pos_z, [95:64] heading,
	                                // [97:96] segment, [103:98] zero
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import tpps_pkg::*;

	geom_t g;
	logic  busy, en;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [31:0]        phase_s1;
	logic [36:0]        phi_s2;
	logic [63:0]        plo_s2;
	logic [LW-1:0]      pos_s3;
	logic [DW-1:0]      num_s4, den_s4;
	div_tag_t           dtag_s4;

	logic               dv;
	logic [31:0]        dq;
	div_tag_t           dtag;

	seg_t               seg_s5, seg_s6;
	logic               vhi_s5;
	logic [31:0]        vlo_s5;
	logic [62:0]        hp_s5;
	logic [63:0]        mxp_s5, mzp_s5;

	logic signed [31:0] h_s6;
	logic signed [36:0] mfx_s6;
	logic signed [34:0] mfz_s6;

	logic signed [CW-1:0] z0_s7;
	cor_tag_t           ctag_s7;

	logic               cv;
	logic signed [CW-1:0] cx, cy;
	cor_tag_t           ctag;

	cor_tag_t           tag_s8;
	logic               cneg_s8, sneg_s8;
	logic [63:0]        pcx_s8, pcs_s8;

	logic [31:0]        x_q, z_q, h_q;
	seg_t               seg_q;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en && !busy;

	tpps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.geom      (g)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid && s_tready;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= dv;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= cv;
			m_tvalid <= v_s8;
		end
	end

	// lap position = phase * total / 2^32
	always_ff @(posedge clk) begin
		if (en) begin
			phase_s1 <= s_tdata;
			phi_s2   <= 37'(64'(phase_s1) * 64'(g.total[LW-1:32]));
			plo_s2   <= 64'(phase_s1) * 64'(g.total[31:0]);
			pos_s3   <= LW'(phi_s2 + 37'(plo_s2[63:32]));
		end
	end

	// segment search against the running boundaries
	always_ff @(posedge clk) begin
		if (en) begin
			if (pos_s3 < g.c1) begin
				dtag_s4.seg  <= SEG_BIG_ARC;
				dtag_s4.none <= 1'b0;
				num_s4 <= DW'(pos_s3);
				den_s4 <= g.lim0;
			end else if (pos_s3 < g.c2) begin
				dtag_s4.seg  <= SEG_UPPER;
				dtag_s4.none <= 1'b0;
				num_s4 <= DW'(pos_s3 - g.c1);
				den_s4 <= DW'(g.tl);
			end else if (pos_s3 < g.c3) begin
				dtag_s4.seg  <= SEG_SMALL_ARC;
				dtag_s4.none <= 1'b0;
				num_s4 <= DW'(pos_s3 - g.c2);
				den_s4 <= g.lim2;
			end else begin
				dtag_s4.seg  <= SEG_LOWER;
				dtag_s4.none <= !(pos_s3 < g.total);
				num_s4 <= DW'(pos_s3 - g.c3);
				den_s4 <= DW'(g.tl);
			end
		end
	end

	tpps_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_num    (num_s4),
		.in_den    (den_s4),
		.in_tag    (dtag_s4),
		.out_valid (dv),
		.out_q     (dq),
		.out_tag   (dtag)
	);

	// fraction products; a fraction of exactly one is carried as vhi
	logic [30:0] hop, hop_s6;
	assign hop    = (dtag.seg == SEG_BIG_ARC) ? g.span : g.two_t;
	assign hop_s6 = (seg_s5 == SEG_BIG_ARC) ? g.span : g.two_t;

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s5 <= dtag.seg;
			vhi_s5 <= dtag.none;
			vlo_s5 <= dtag.none ? 32'd0 : dq;
			hp_s5  <= 63'(64'(dtag.none ? 32'd0 : dq) * 64'(hop));
			mxp_s5 <= 64'(dtag.none ? 32'd0 : dq) * 64'(g.dx_mag[31:0]);
			mzp_s5 <= 64'(dtag.none ? 32'd0 : dq) * 64'(g.dz_mag[31:0]);
		end
	end

	logic [30:0] hsub;
	logic [35:0] mx;
	logic [33:0] mz;
	assign hsub = vhi_s5 ? hop_s6 : 31'(hp_s5 >> 32);
	assign mx   = vhi_s5 ? g.dx_mag :
		36'(64'(g.dx_mag[35:32]) * 64'(vlo_s5)) + 36'(mxp_s5 >> 32);
	assign mz   = vhi_s5 ? g.dz_mag :
		34'(64'(g.dz_mag[33:32]) * 64'(vlo_s5)) + 34'(mzp_s5 >> 32);

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s6 <= seg_s5;
			mfx_s6 <= g.dx_neg ? -signed'({1'b0, mx}) : signed'({1'b0, mx});
			mfz_s6 <= g.dz_neg ? -signed'({1'b0, mz}) : signed'({1'b0, mz});
			case (seg_s5)
				SEG_BIG_ARC:   h_s6 <= signed'(32'(TWO_PI_Q28 - 31'(g.t))) -
					signed'(32'(hsub));
				SEG_UPPER:     h_s6 <= signed'(32'(g.t));
				SEG_SMALL_ARC: h_s6 <= signed'(32'(g.t)) - signed'(32'(hsub));
				default:       h_s6 <= -signed'(32'(g.t));
			endcase
		end
	end

	// straight runs and angle folding into [-pi/2, pi/2]
	logic signed [32:0] hw, hf;
	logic               flip;
	always_comb begin
		hw   = 33'(h_s6);
		flip = 1'b0;
		if (hw > signed'(33'(PI_Q28))) begin
			hw = hw - signed'(33'(TWO_PI_Q28));
		end
		hf = hw;
		if (hw > signed'(33'(HALF_PI_Q28))) begin
			hf   = hw - signed'(33'(PI_Q28));
			flip = 1'b1;
		end else if (hw < -signed'(33'(HALF_PI_Q28))) begin
			hf   = hw + signed'(33'(PI_Q28));
			flip = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z0_s7        <= CW'({hf, 2'b00});
			ctag_s7.seg  <= seg_s6;
			ctag_s7.flip <= flip;
			ctag_s7.h    <= h_s6;
			if (seg_s6 == SEG_UPPER) begin
				ctag_s7.linx <= XW'(g.p1x) + XW'(mfx_s6);
				ctag_s7.linz <= signed'(XW'(g.p1y)) + XW'(mfz_s6);
			end else begin
				ctag_s7.linx <= XW'(g.p2x) - XW'(mfx_s6);
				ctag_s7.linz <= -signed'(XW'(g.p2y)) + XW'(mfz_s6);
			end
		end
	end

	tpps_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.in_z      (z0_s7),
		.in_tag    (ctag_s7),
		.out_valid (cv),
		.out_x     (cx),
		.out_y     (cy),
		.out_tag   (ctag)
	);

	// radius times cosine and sine
	logic [31:0] rad, cmag, smag;
	assign rad  = (ctag.seg == SEG_BIG_ARC) ? g.rb : g.rs;
	assign cmag = cx[CW-1] ? 32'(-cx) : 32'(cx);
	assign smag = cy[CW-1] ? 32'(-cy) : 32'(cy);

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s8  <= ctag;
			cneg_s8 <= cx[CW-1] ^ ctag.flip;
			sneg_s8 <= cy[CW-1] ^ ctag.flip;
			pcx_s8  <= 64'(cmag) * 64'(rad);
			pcs_s8  <= 64'(smag) * 64'(rad);
		end
	end

	function automatic logic [31:0] sat32(input logic signed [XW-1:0] a);
		logic [31:0] r;
		if (a > signed'(XW'(32'sh7FFFFFFF))) begin
			r = 32'h7FFFFFFF;
		end else if (a < signed'(XW'(-33'sh80000000))) begin
			r = 32'h80000000;
		end else begin
			r = a[31:0];
		end
		return r;
	endfunction

	logic signed [XW-1:0] arcx, arcz, fx, fz;
	always_comb begin
		arcx = cneg_s8 ? -signed'(XW'(pcx_s8 >> 30)) : signed'(XW'(pcx_s8 >> 30));
		arcz = sneg_s8 ? -signed'(XW'(pcs_s8 >> 30)) : signed'(XW'(pcs_s8 >> 30));
		case (tag_s8.seg)
			SEG_BIG_ARC: begin
				fx = arcx;
				fz = arcz;
			end
			SEG_SMALL_ARC: begin
				fx = signed'(XW'(g.cd)) + arcx;
				fz = arcz;
			end
			default: begin
				fx = tag_s8.linx;
				fz = tag_s8.linz;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q   <= sat32(fx);
			z_q   <= sat32(fz);
			h_q   <= tag_s8.h;
			seg_q <= tag_s8.seg;
		end
	end

	assign m_tdata = {6'd0, seg_q, h_q, z_q, x_q};

endmodule

// File: sv/tpps_checker.sv
// Port-level checks for the track path point sampler, bound to the top level.
module tpps_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [103:0] m_tdata,
	input logic         cfg_valid,
	input logic         cfg_ready
);
	import tpps_pkg::*;

	logic signed [31:0] hd;
	logic [1:0]         sg;
	assign hd = signed'(m_tdata[95:64]);
	assign sg = m_tdata[97:96];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !s_tready)
		else $error("input taken right after a register write");

	a_lower_heading: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && sg == SEG_LOWER |-> hd <= 32'sd0)
		else $error("lower tangent heading not negative");

	a_upper_heading: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (sg == SEG_UPPER || sg == SEG_BIG_ARC) |-> hd >= 32'sd0)
		else $error("upper run or big arc heading negative");

	a_small_heading: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && sg == SEG_SMALL_ARC |->
			hd <= signed'(32'(PI_Q28)) && hd >= -signed'(32'(PI_Q28)))
		else $error("small arc heading beyond pi");

endmodule

bind track_path_point_sampler tpps_checker u_tpps_checker (.*);
